>>> rtl/hrls_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the horizontal run-length smoothing block
// no dependencies
package hrls_pkg;

	localparam int GAP_W = 7;
	localparam logic [GAP_W-1:0] GAP_RESET = 7'd45;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_EMIT = 4'b0100,
		ST_LAST = 4'b1000
	} state_t;

	typedef struct packed {
		logic accept;
		logic rd;
		logic emit_held;
		logic emit_last;
	} dp_cmd_t;

	typedef struct packed {
		logic hold;
		logic run_zero;
		logic idx_last;
		logic out_free;
	} dp_sts_t;

endpackage

>>> rtl/hrls_ctrl.sv
`timescale 1ns / 1ps
// controller state machine: accepts a pixel, sequences reads of held pixels
// depends on hrls_pkg
module hrls_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  hrls_pkg::dp_sts_t sts,
	output hrls_pkg::dp_cmd_t cmd
);
	import hrls_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_tready      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (sts.hold) begin
						state_d = ST_IDLE;
					end else if (sts.run_zero) begin
						state_d = ST_LAST;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_held = 1'b1;
					state_d = sts.idx_last ? ST_LAST : ST_READ;
				end
			end
			ST_LAST: begin
				if (sts.out_free) begin
					cmd.emit_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/hrls_dp.sv
`timescale 1ns / 1ps
// datapath: threshold register, run counters, held-pixel memory, output register
// depends on hrls_pkg
module hrls_dp #(
	parameter int MAX_GAP    = 64,
	parameter int PIXEL_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [PIXEL_BITS-1:0]      pixel,
	input  logic                       row_end,
	input  logic                       frame_end,
	input  logic                       cfg_valid,
	input  logic [hrls_pkg::GAP_W-1:0] cfg_data,
	input  hrls_pkg::dp_cmd_t          cmd,
	output hrls_pkg::dp_sts_t          sts,
	input  logic                       m_tready,
	output logic                       out_valid,
	output logic [PIXEL_BITS-1:0]      pixel_out,
	output logic                       run_last,
	output logic                       row_last,
	output logic                       frame_last
);
	import hrls_pkg::*;

	localparam int DEPTH = MAX_GAP - 1;
	localparam int RW    = $clog2(MAX_GAP);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = (RW + 1 > GAP_W) ? RW + 1 : GAP_W;

	logic [PIXEL_BITS-1:0] mem [DEPTH];
	logic [PIXEL_BITS-1:0] rd_data_q;
	logic [GAP_W-1:0]      gap_q;
	logic [RW-1:0]         run_q;
	logic                  long_q;
	logic [RW-1:0]         cnt_q;
	logic [RW-1:0]         idx_q;
	logic                  ink_q;
	logic [PIXEL_BITS-1:0] pix_q;
	logic                  row_q;
	logic                  frame_q;
	logic                  out_valid_q;
	logic [PIXEL_BITS-1:0] pix_out_q;
	logic                  run_last_q;
	logic                  row_last_q;
	logic                  frame_last_q;
	logic                  is_ink;
	logic                  row_in;
	logic                  thresh;
	logic                  hold;

	assign is_ink = (pixel == '0);
	assign row_in = row_end | frame_end;
	assign thresh = ((CW'(run_q) + CW'(1)) >= CW'(gap_q)) || (run_q >= RW'(DEPTH));
	assign hold   = !is_ink && !long_q && !thresh && !row_in;

	assign sts.hold     = hold;
	assign sts.run_zero = (run_q == '0);
	assign sts.idx_last = ((RW+1)'(idx_q) + (RW+1)'(1)) == (RW+1)'(cnt_q);
	assign sts.out_free = !out_valid_q || m_tready;

	// held pixel store
	always_ff @(posedge clk) begin
		if (cmd.accept && hold) begin
			mem[run_q[AW-1:0]] <= pixel;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q  <= GAP_RESET;
			run_q  <= '0;
			long_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (cfg_valid) begin
				gap_q <= cfg_data;
			end
			if (cmd.accept) begin
				idx_q <= '0;
				if (hold) begin
					run_q <= run_q + RW'(1);
				end else begin
					run_q  <= '0;
					long_q <= !is_ink && (long_q || thresh) && !row_in;
				end
			end else if (cmd.emit_held) begin
				idx_q <= idx_q + RW'(1);
			end
		end
	end

	// captured item
	always_ff @(posedge clk) begin
		if (cmd.accept && !hold) begin
			cnt_q   <= run_q;
			ink_q   <= is_ink;
			pix_q   <= pixel;
			row_q   <= row_in;
			frame_q <= frame_end;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_held || cmd.emit_last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_held) begin
			pix_out_q    <= ink_q ? '0 : rd_data_q;
			run_last_q   <= 1'b0;
			row_last_q   <= 1'b0;
			frame_last_q <= 1'b0;
		end else if (cmd.emit_last) begin
			pix_out_q    <= pix_q;
			run_last_q   <= 1'b1;
			row_last_q   <= row_q;
			frame_last_q <= frame_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_out  = pix_out_q;
	assign run_last   = run_last_q;
	assign row_last   = row_last_q;
	assign frame_last = frame_last_q;

`ifndef SYNTHESIS
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_q <= RW'(DEPTH))
		else $error("held run exceeds store depth");
	a_long_empty: assert property (@(posedge clk) disable iff (!arst_n)
		long_q |-> (run_q == '0))
		else $error("pixels held during a long run");
	a_hold_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && hold) |=> (run_q == $past(run_q) + RW'(1)))
		else $error("held pixel not counted");
	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> (idx_q < cnt_q))
		else $error("read beyond held run");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_held || cmd.emit_last) |-> (!out_valid_q || m_tready))
		else $error("output beat overwritten");
`endif

endmodule

>>> rtl/horizontal_run_length_smoothing.sv
`timescale 1ns / 1ps
// a passed pixel is captured on its input beat and presented from the output register
// after any released pixels; each released pixel is read from the store and then emitted;
// output may stall on m_tready. A held pixel is stored and emits nothing; input stays ready.
// input is stalled while a run of released pixels and the passed pixel are emitted
// reset: asynchronous active-low arst_n clears the run state and output valid and sets
// gap_threshold to 45; the held-pixel store is not cleared
module horizontal_run_length_smoothing #(
	parameter int MAX_GAP    = 64,
	parameter int PIXEL_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [hrls_pkg::GAP_W-1:0]           cfg_data,   // gap_threshold
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((PIXEL_BITS+7)/8)*8-1:0]      s_tdata,    // pixel
	input  logic                                 s_tlast,    // row_end
	input  logic                                 s_tuser,    // frame_end
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((PIXEL_BITS+7)/8)*8-1:0]      m_tdata,    // pixel_out
	output logic                                 m_tlast,    // run_last
	output logic [1:0]                           m_tuser     // row_last, frame_last
);
	import hrls_pkg::*;

	localparam int DW = ((PIXEL_BITS + 7) / 8) * 8;

	dp_cmd_t               cmd;
	dp_sts_t               sts;
	logic [PIXEL_BITS-1:0] pixel_out;
	logic                  row_last;
	logic                  frame_last;

	assign cfg_ready = 1'b1;

	hrls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hrls_dp #(
		.MAX_GAP    (MAX_GAP),
		.PIXEL_BITS (PIXEL_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (s_tdata[PIXEL_BITS-1:0]),
		.row_end    (s_tlast),
		.frame_end  (s_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.sts        (sts),
		.m_tready   (m_tready),
		.out_valid  (m_tvalid),
		.pixel_out  (pixel_out),
		.run_last   (m_tlast),
		.row_last   (row_last),
		.frame_last (frame_last)
	);

	assign m_tdata = DW'(pixel_out);
	assign m_tuser = {frame_last, row_last};

endmodule
